>>> rtl/core/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// shared types, codes and helpers of the integer to radix digits unit
// ----------------------------------------------------------------------------
package itrd_pkg;

	localparam int DEF_MAX_RADIX  = 16;
	localparam int DEF_VALUE_BITS = 64;

	localparam int TABLE_BYTES = 16;
	localparam int TABLE_W     = 8 * TABLE_BYTES;
	localparam int RADIX_W     = 5;   // holds a radix of up to 16
	localparam int DIGIT_W     = 4;   // one digit index
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 2;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int MIN_RADIX   = 2;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_DIGITS_LOW  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DIGITS_HIGH = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DIGIT = 2'd0,
		STATUS_NEG   = 2'd1,
		STATUS_BAD   = 2'd2
	} status_t;

	// divider control from the sequencer
	typedef struct packed {
		logic start;   // load dividend, begin first digit
		logic next;    // begin next digit on the kept quotient
	} dv_ctrl_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] digit;
		logic               quo_zero;
	} dv_sts_t;

	function automatic logic [CHAR_W-1:0] table_byte(
		input logic [TABLE_W-1:0] tbl,
		input logic [DIGIT_W-1:0] idx
	);
		return tbl[{idx, 3'b000} +: CHAR_W];
	endfunction

endpackage

>>> rtl/core/itrd_ram.sv
// ----------------------------------------------------------------------------
// itrd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module itrd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/itrd_table_check.sv
// ----------------------------------------------------------------------------
// itrd_table_check
// derives radix and validity of the digit table, registered
// ----------------------------------------------------------------------------
module itrd_table_check #(
	parameter int MAX_RADIX = itrd_pkg::DEF_MAX_RADIX
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [itrd_pkg::TABLE_W-1:0] tbl,
	output logic [itrd_pkg::RADIX_W-1:0] radix,
	output logic                         bad
);

	import itrd_pkg::*;

	logic [RADIX_W-1:0] radix_c;
	logic               sign_c;
	logic               dup_c;
	logic [RADIX_W-1:0] radix_q;
	logic               bad_q;

	always_comb begin
		logic [CHAR_W-1:0] b;
		radix_c = RADIX_W'(MAX_RADIX);
		// first zero byte ends the table
		for (int i = MAX_RADIX - 1; i >= 0; i--) begin
			if (table_byte(tbl, DIGIT_W'(i)) == CHAR_NUL) begin
				radix_c = RADIX_W'(i);
			end
		end
		sign_c = 1'b0;
		dup_c  = 1'b0;
		for (int i = 0; i < MAX_RADIX; i++) begin
			b = table_byte(tbl, DIGIT_W'(i));
			if (RADIX_W'(i) < radix_c) begin
				if (b == CHAR_PLUS || b == CHAR_MINUS) begin
					sign_c = 1'b1;
				end
				for (int j = i + 1; j < MAX_RADIX; j++) begin
					if (RADIX_W'(j) < radix_c && b == table_byte(tbl, DIGIT_W'(j))) begin
						dup_c = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
			bad_q   <= 1'b1;
		end else begin
			radix_q <= radix_c;
			bad_q   <= sign_c | dup_c | (radix_c < RADIX_W'(MIN_RADIX));
		end
	end

	assign radix = radix_q;
	assign bad   = bad_q;

endmodule

>>> rtl/core/itrd_divider.sv
// ----------------------------------------------------------------------------
// itrd_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module itrd_divider #(
	parameter int QUO_W = itrd_pkg::DEF_VALUE_BITS - 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  itrd_pkg::dv_ctrl_t           ctrl,
	input  logic [QUO_W-1:0]             dividend,
	input  logic [itrd_pkg::RADIX_W-1:0] radix,
	output itrd_pkg::dv_sts_t            sts
);

	import itrd_pkg::*;

	localparam int BIT_W = $clog2(QUO_W);

	logic [QUO_W-1:0]   quo_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [BIT_W-1:0]   bit_q;
	logic               busy_q;
	logic               done_q;

	logic [RADIX_W-1:0] trial;
	logic               ge;
	logic [RADIX_W-1:0] diff;

	// shift in next dividend bit, compare and subtract
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign ge    = (trial >= radix);
	assign diff  = trial - radix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start || ctrl.next) begin
				if (ctrl.start) begin
					quo_q <= dividend;
				end
				rem_q  <= '0;
				bit_q  <= BIT_W'(QUO_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[QUO_W-2:0], ge};
				rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts = '{done: done_q, digit: rem_q, quo_zero: (quo_q == '0)};

endmodule

>>> rtl/core/integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// converts a signed value to digit characters, most significant first
// ----------------------------------------------------------------------------
// One value comes in per transaction on the slave side; the unit then emits
// its digits on the master side, one character per transaction, the last one
// marked with tlast. The digit characters come from a table of up to 16 bytes
// in the two configuration registers; the radix is the byte count before the
// first zero byte. A bad table (radix below 2, a sign character, or a
// repeated character) gives a single error transaction, a negative value a
// single empty one. The unit works on one value at a time, and s_tready
// stays low from acceptance until the last result is loaded into the
// output register. A check step comes first; then every digit runs the
// shared bit-serial divider over all VALUE_BITS-1 quotient bits, and the
// digits are then read back from the digit memory one at a time, most
// significant first. A stalled receiver holds up the read-out.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit #(
	parameter int MAX_RADIX  = itrd_pkg::DEF_MAX_RADIX,
	parameter int VALUE_BITS = itrd_pkg::DEF_VALUE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [itrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [itrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,   // [63:0] value
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [itrd_pkg::CHAR_W-1:0]     m_tdata,   // [7:0] digit_char
	output logic [itrd_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
	output logic                            m_tlast
);

	import itrd_pkg::*;

	localparam int QUO_W  = VALUE_BITS - 1;
	localparam int ADDR_W = $clog2(VALUE_BITS);

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_DIV   = 5'b00100,
		S_READ  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_n;

	// configuration registers, the digit table
	logic [CFG_DATA_W-1:0] digits_low_q;
	logic [CFG_DATA_W-1:0] digits_high_q;
	logic [TABLE_W-1:0]    tbl;

	// item registers
	logic [QUO_W-1:0]  val_q;
	logic              neg_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] idx_n;

	// table check
	logic [RADIX_W-1:0] radix;
	logic               tbl_bad;

	// divider
	dv_ctrl_t dv_ctrl;
	dv_sts_t  dv_sts;

	// digit memory
	logic               ram_we;
	logic               ram_re;
	logic [DIGIT_W-1:0] ram_rdata;

	// output register
	logic              out_free;
	logic              out_ld;
	logic [CHAR_W-1:0] out_char;
	status_t           out_status;
	logic              out_last;
	logic              m_tvalid_q;
	logic [CHAR_W-1:0] m_tdata_q;
	status_t           m_tuser_q;
	logic              m_tlast_q;

	assign tbl = {digits_high_q, digits_low_q};

	// configuration writes, other indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_low_q  <= '0;
			digits_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DIGITS_LOW:  digits_low_q  <= cfg_wdata;
				REG_DIGITS_HIGH: digits_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	itrd_table_check #(
		.MAX_RADIX (MAX_RADIX)
	) u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.tbl    (tbl),
		.radix  (radix),
		.bad    (tbl_bad)
	);

	itrd_divider #(
		.QUO_W (QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dv_ctrl),
		.dividend (val_q),
		.radix    (radix),
		.sts      (dv_sts)
	);

	// digit indexes, least significant at address zero
	itrd_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (VALUE_BITS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (dv_sts.digit),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// sequencer
	always_comb begin
		state_n       = state_q;
		idx_n         = idx_q;
		dv_ctrl.start = 1'b0;
		dv_ctrl.next  = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		out_ld        = 1'b0;
		out_char      = CHAR_NUL;
		out_status    = STATUS_DIGIT;
		out_last      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					idx_n   = '0;
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				// table check ranks above the sign check
				if (tbl_bad || neg_q) begin
					if (out_free) begin
						out_ld     = 1'b1;
						out_status = tbl_bad ? STATUS_BAD : STATUS_NEG;
						state_n    = S_IDLE;
					end
				end else begin
					dv_ctrl.start = 1'b1;
					state_n       = S_DIV;
				end
			end
			S_DIV: begin
				if (dv_sts.done) begin
					ram_we = 1'b1;
					if (dv_sts.quo_zero) begin
						// idx stays on the most significant digit
						state_n = S_READ;
					end else begin
						idx_n        = idx_q + 1'b1;
						dv_ctrl.next = 1'b1;
					end
				end
			end
			S_READ: begin
				ram_re  = 1'b1;
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_ld   = 1'b1;
					out_char = table_byte(tbl, ram_rdata);
					out_last = (idx_q == '0);
					if (idx_q == '0) begin
						state_n = S_IDLE;
					end else begin
						idx_n   = idx_q - 1'b1;
						state_n = S_READ;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			if (s_tvalid && s_tready) begin
				neg_q <= s_tdata[VALUE_BITS-1];
			end
		end
	end

	// low bits only count, the sign bit is split off
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			val_q <= s_tdata[QUO_W-1:0];
		end
	end

	// output register, a new result loads only when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_tdata_q <= out_char;
			m_tuser_q <= out_status;
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// error and empty results are single transactions with no character
	a_status_single : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STATUS_DIGIT) |-> (m_tlast && m_tdata == CHAR_NUL))
		else $error("error or empty result not a lone zero transaction");

	// the divider only finishes a digit while the sequencer waits for it
	a_div_done_in_div : assert property (@(posedge clk) disable iff (!arst_n)
		dv_sts.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide phase");

	// digit count stays within the stack
	a_idx_range : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (idx_q <= ADDR_W'(QUO_W - 1)))
		else $error("digit index beyond the longest possible digit string");

	// an accepted value is always checked next
	a_accept_check : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_CHECK))
		else $error("accepted value did not enter the check phase");

endmodule

>>> sim/tb_integer_to_radix_digits_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits_unit
// self-checking bench for the integer to radix digits unit
// ----------------------------------------------------------------------------
// A queue of values feeds a stream driver, and a monitor predicts the digit
// characters of every accepted value from its own copy of the digit table.
// Each result transaction is checked field by field against the oldest
// prediction. A directed part covers the reset table, writes to unused
// indexes, decimal, hex, binary and broken tables and the value extremes.
// Random phases follow, each under a fresh random table. Both sides idle at
// random, one phase runs with no idling, and one phase holds the receiver
// off long enough to back the unit up into its input.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits_unit;
	import itrd_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 6;
	localparam int IDLE_PCT         = 14;
	localparam int HOLD_CYCLES      = 1500;
	localparam int WATCHDOG_LIMIT   = 20000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int DRAIN_CYCLES     = 80;
	localparam int RANDOM_PHASES    = 6;
	localparam int VALUES_PER_PHASE = 18;

	// indexes the unit does not decode
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

	// digit tables, character 0 in the lowest byte
	localparam logic [63:0] DEC_LOW  = 64'h3736_3534_3332_3130; // "01234567"
	localparam logic [63:0] DEC_HIGH = 64'h0000_0000_0000_3938; // "89"
	localparam logic [63:0] HEX_HIGH = 64'h6665_6463_6261_3938; // "89abcdef"
	localparam logic [63:0] BIN_LOW  = 64'h0000_0000_0000_3130; // "01"

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		status_t           st;
		logic              last;
	} char_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [CHAR_W-1:0]     m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  m_tlast;

	// own copy of the digit table registers
	logic [63:0]  table_low = '0;
	logic [63:0]  table_high = '0;

	logic [63:0]  value_q [$];     // values waiting to be offered
	char_result_t digit_q [$];     // predicted characters, oldest first

	logic         value_taken = 1'b0;
	bit           quiet = 1'b0;    // no random idling on either side
	int           stall_asked = 0;
	int           stall_seen = 0;
	int           stall_left = 0;
	int           quiet_cycles = 0;
	int           mismatches = 0;
	int           values_done = 0;
	int           chars_done = 0;
	int           tables_used = 0;

	integer_to_radix_digits_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// work out the characters the unit owes for one value under the current table
	function automatic void expect_digits(input logic [63:0] value);
		logic [TABLE_W-1:0] tbl;
		logic [CHAR_W-1:0]  c;
		logic [62:0]        q;
		logic [DIGIT_W-1:0] stack [64];
		int                 radix;
		int                 cnt;
		int                 i;
		int                 j;
		bit                 bad;
		bit                 ended;
		tbl = {table_high, table_low};
		radix = 0;
		bad = 1'b0;
		ended = 1'b0;
		// radix is the run of nonzero bytes; a sign character anywhere in it spoils the table
		for (i = 0; i < DEF_MAX_RADIX; i++) begin
			c = tbl[8*i +: 8];
			if (c == CHAR_NUL)
				ended = 1'b1;
			if (!ended) begin
				radix++;
				if (c == CHAR_PLUS || c == CHAR_MINUS)
					bad = 1'b1;
			end
		end
		if (radix < MIN_RADIX)
			bad = 1'b1;
		for (i = 0; i < radix; i++)
			for (j = i + 1; j < radix; j++)
				if (tbl[8*i +: 8] == tbl[8*j +: 8])
					bad = 1'b1;
		// table check wins over the sign check
		if (bad)
			digit_q.push_back('{ch: CHAR_NUL, st: STATUS_BAD, last: 1'b1});
		else if (value[63])
			digit_q.push_back('{ch: CHAR_NUL, st: STATUS_NEG, last: 1'b1});
		else begin
			q = value[62:0];
			cnt = 0;
			do begin
				stack[cnt] = DIGIT_W'(q % radix);
				q = q / radix;
				cnt++;
			end while (q != 0);
			// most significant digit first
			for (i = cnt - 1; i >= 0; i--)
				digit_q.push_back('{ch: tbl[8*stack[i] +: 8], st: STATUS_DIGIT, last: i == 0});
		end
	endfunction

	// input side: offer the next queued value, or idle now and then
	always @(negedge clk) begin
		if (!s_tvalid || value_taken) begin
			if (value_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= value_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: random back-pressure, plus a long hold-off when one is asked for
	always @(negedge clk) begin
		if (stall_seen != stall_asked) begin
			stall_seen <= stall_asked;
			stall_left <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// monitor: predict on every accepted value, check every result transaction
	always @(posedge clk) begin
		char_result_t want;
		value_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			expect_digits(s_tdata);
			values_done++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			chars_done++;
			if (digit_q.size() == 0) begin
				$error("result with nothing expected: digit_char %h status %0d last %0b",
					m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				want = digit_q.pop_front();
				if (m_tdata !== want.ch) begin
					$error("digit_char: expected %h, got %h", want.ch, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, m_tuser);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long without any transaction or register write
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results still owed",
				WATCHDOG_LIMIT, digit_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// block until every queued value is in and every predicted character is out
	task automatic wait_drained();
		@(posedge clk);
		while (value_q.size() != 0 || s_tvalid || digit_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		if (addr == REG_DIGITS_LOW)
			table_low = data;
		else if (addr == REG_DIGITS_HIGH)
			table_high = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_table(input logic [63:0] low_bytes, input logic [63:0] high_bytes);
		write_reg(REG_DIGITS_LOW, low_bytes);
		write_reg(REG_DIGITS_HIGH, high_bytes);
		tables_used++;
	endtask

	initial begin
		logic [7:0]  b [TABLE_BYTES];
		logic [7:0]  c;
		logic [63:0] v;
		logic [63:0] rnd_low;
		logic [63:0] rnd_high;
		bit          clash;
		int          radix;
		int          i;
		int          j;
		int          k;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset table is all zeros, so every value is refused
		value_q.push_back(64'd5);
		value_q.push_back(NEG_ONE);
		wait_drained();

		// writes to undecoded indexes must leave the table untouched
		write_reg(REG_SPARE_2, DEC_LOW);
		write_reg(REG_SPARE_3, DEC_HIGH);
		value_q.push_back(64'd7);
		wait_drained();

		// decimal: zero, one digit, carry into two digits, both ends of the range
		load_table(DEC_LOW, DEC_HIGH);
		value_q.push_back(64'd0);
		value_q.push_back(64'd1);
		value_q.push_back(64'd9);
		value_q.push_back(64'd10);
		value_q.push_back(POS_MAX);
		value_q.push_back(NEG_MIN);
		value_q.push_back(NEG_ONE);
		value_q.push_back(64'd1234567890);
		wait_drained();

		// full sixteen-character table with no terminator
		load_table(DEC_LOW, HEX_HIGH);
		value_q.push_back(64'hF);
		value_q.push_back(64'h10);
		value_q.push_back(POS_MAX);
		value_q.push_back(64'h0123_4567_89AB_CDEF);
		wait_drained();

		// binary: the largest value gives the longest digit run
		load_table(BIN_LOW, 64'd0);
		value_q.push_back(POS_MAX);
		value_q.push_back(64'd1);
		value_q.push_back(64'd0);
		wait_drained();

		// plus sign inside the table
		load_table(64'h0000_0000_0032_2B30, 64'd0);
		value_q.push_back(64'd7);
		wait_drained();

		// minus sign in the high register
		load_table(DEC_LOW, 64'h0000_0000_0000_2D38);
		value_q.push_back(64'd7);
		wait_drained();

		// repeated character, last byte against the first
		load_table(DEC_LOW, 64'h3066_6564_6362_6139);
		value_q.push_back(64'd7);
		wait_drained();

		// a single character is no radix
		load_table(64'h0000_0000_0000_0041, 64'd0);
		value_q.push_back(64'd7);
		wait_drained();

		// "ABC" then a terminator; sign bytes and junk past it do not count
		load_table(64'h0000_2D2B_0043_4241, NEG_ONE);
		value_q.push_back(64'd5);
		wait_drained();

		// every byte 0xff: all repeats
		load_table(NEG_ONE, NEG_ONE);
		value_q.push_back(64'd5);
		wait_drained();

		// random phases, each under a fresh table
		for (k = 0; k < RANDOM_PHASES; k++) begin
			case (k)
				0:       radix = 10;
				1:       radix = DEF_MAX_RADIX;
				2:       radix = MIN_RADIX;
				default: radix = $urandom_range(MIN_RADIX, DEF_MAX_RADIX);
			endcase
			// distinct nonzero characters, no signs
			for (i = 0; i < radix; i++) begin
				clash = 1'b1;
				while (clash) begin
					c = 8'($urandom_range(1, 255));
					clash = (c == CHAR_PLUS || c == CHAR_MINUS);
					for (j = 0; j < i; j++)
						if (b[j] == c)
							clash = 1'b1;
				end
				b[i] = c;
			end
			// terminator, then junk the unit has to ignore
			for (i = radix; i < TABLE_BYTES; i++)
				b[i] = (i == radix) ? CHAR_NUL : 8'($urandom_range(0, 255));
			if (k == 4) begin
				case ($urandom_range(0, 2))
					0:       b[$urandom_range(0, radix - 1)] =
						$urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
					1:       b[$urandom_range(1, radix - 1)] = b[0];
					default: b[1] = CHAR_NUL;
				endcase
			end
			for (i = 0; i < 8; i++) begin
				rnd_low[8*i +: 8]  = b[i];
				rnd_high[8*i +: 8] = b[i + 8];
			end
			load_table(rnd_low, rnd_high);

			@(posedge clk);
			quiet = (k == 0);
			if (k == 3) begin
				// short value first so the unit has a result parked when the hold-off bites
				stall_asked++;
				value_q.push_back(64'($urandom_range(0, 255)));
			end
			for (j = 0; j < VALUES_PER_PHASE; j++) begin
				v = {$urandom, $urandom};
				case ($urandom_range(0, 9))
					0, 1, 2: ;   // full width, about half negative
					3:       v = 64'($urandom_range(0, 3));
					default: v = v & ((64'd1 << $urandom_range(1, 62)) - 64'd1);
				endcase
				value_q.push_back(v);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("converted %0d values into %0d checked characters under %0d digit tables",
			values_done, chars_done, tables_used);
		$display("covered reset, decimal, hex, binary, broken and random tables, one long hold-off");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/itrd_pkg.sv
rtl/core/itrd_ram.sv
rtl/core/itrd_table_check.sv
rtl/core/itrd_divider.sv
rtl/core/integer_to_radix_digits_unit.sv
sim/tb_integer_to_radix_digits_unit.sv
